// ===== design/sms_pkg.sv =====
`default_nettype none

package sms_pkg;

   typedef struct packed {
      logic [1:0]  host_command;
      logic [3:0]  goto_buttons;
      logic [2:0]  sample_buttons;
      logic [3:0]  jog_buttons;
      logic [2:0]  position_sensors;
      logic [2:0]  ring_sensors;
      logic [2:0]  sample_sensors;
      logic        test_jumper;
      logic [31:0] time_ms;
      logic [9:0]  speed_sample;
   } req_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic               motor_enabled;
      logic [2:0]         step_mask;
      logic               mode_step_right;
      logic               relay_on;
      logic [1:0]         beep_code;
      logic [3:0]         message_code;
      logic signed [15:0] position;
      logic [15:0]        step_delay_us;
   } rsp_type;

   typedef enum logic [6:0] {
      ST_STOP      = 7'b0000001,
      ST_POS1      = 7'b0000010,
      ST_POS2      = 7'b0000100,
      ST_POS3      = 7'b0001000,
      ST_CATCH_BOT = 7'b0010000,
      ST_CATCH_TOP = 7'b0100000,
      ST_RELEASE   = 7'b1000000
   } state_type;

   localparam logic [2:0] MODE_STOP      = 3'd0;
   localparam logic [2:0] MODE_POS1      = 3'd1;
   localparam logic [2:0] MODE_POS2      = 3'd2;
   localparam logic [2:0] MODE_POS3      = 3'd3;
   localparam logic [2:0] MODE_CATCH_BOT = 3'd4;
   localparam logic [2:0] MODE_CATCH_TOP = 3'd5;
   localparam logic [2:0] MODE_RELEASE   = 3'd6;

   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_STOP    = 2'd1;
   localparam logic [1:0] ACT_GO_POS1 = 2'd2;
   localparam logic [1:0] ACT_GO_POS2 = 2'd3;

   localparam logic [1:0] BEEP_NONE  = 2'd0;
   localparam logic [1:0] BEEP_ATTN  = 2'd1;
   localparam logic [1:0] BEEP_ERR   = 2'd2;
   localparam logic [1:0] BEEP_ALARM = 2'd3;

   localparam logic [3:0] MSG_NONE          = 4'd0;
   localparam logic [3:0] MSG_STOP          = 4'd1;
   localparam logic [3:0] MSG_AT_POS1       = 4'd2;
   localparam logic [3:0] MSG_POS_ERROR     = 4'd3;
   localparam logic [3:0] MSG_IN_POS2       = 4'd4;
   localparam logic [3:0] MSG_NO_CATCH      = 4'd5;
   localparam logic [3:0] MSG_NO_RELEASE    = 4'd6;
   localparam logic [3:0] MSG_OVER_DETECTOR = 4'd7;
   localparam logic [3:0] MSG_CAUGHT        = 4'd8;
   localparam logic [3:0] MSG_FALLING       = 4'd9;
   localparam logic [3:0] MSG_RELEASED      = 4'd10;
   localparam logic [3:0] MSG_TEST_POS2     = 4'd11;
   localparam logic [3:0] MSG_TEST_POS3     = 4'd12;

   localparam logic [1:0] REG_BASE_DELAY  = 2'd0;
   localparam logic [1:0] REG_SPEED_GAIN  = 2'd1;
   localparam logic [1:0] REG_JOG_TIMEOUT = 2'd2;
   localparam logic [1:0] REG_TEST_PERIOD = 2'd3;

   localparam logic [15:0] BASE_DELAY_RESET  = 16'd1000;
   localparam logic [3:0]  SPEED_GAIN_RESET  = 4'd3;
   localparam logic [15:0] JOG_TIMEOUT_RESET = 16'd100;
   localparam logic [15:0] TEST_PERIOD_RESET = 16'd250;

   localparam int RESAMPLE_EVERY = 5;

endpackage

`default_nettype wire

// ===== design/spindle_motion_sequencer_top.sv =====
// Spindle motion sequencer: one control pass per request beat.
// A request beat carries the decoded host command, the button, sensor and
// jumper bits, the millisecond time and the speed sample. Each request beat
// produces exactly one response beat with the mode, motor enable, step
// requests and direction, relay state, beep and message codes, the step
// position and the current step delay.
// A request is captured in an input register and evaluated against the
// sequencer state once the response register can take a beat; the pass
// logic lies between the input register and the response register. One
// beat per cycle is sustained while the receiver does not stall.
// When the receiver stalls, the response register holds its beat and the
// input register still takes one more request; only when both are full is
// req_stall raised.
// Reset (synchronous, active high) returns the sequencer to stop mode with
// the motor and relay off, position zero, the step delay at 1000 us and the
// configuration registers at their defaults. The configuration registers
// are to be written over the APB port only while no beat is in flight; the
// block itself does not enforce this.
`default_nettype none

module spindle_motion_sequencer_top
   import sms_pkg::*;
#(
   parameter int POSITION_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int PB = POSITION_BITS;
   localparam longint unsigned HALF_RANGE = 64'd1 << (PB - 1);
   localparam logic [2:0] MAX_RES = 3'((HALF_RANGE - 64'd1) % RESAMPLE_EVERY);
   localparam logic [2:0] MIN_RES =
      3'((RESAMPLE_EVERY - (HALF_RANGE % RESAMPLE_EVERY)) % RESAMPLE_EVERY);
   localparam logic [2:0] RES_LAST = 3'(RESAMPLE_EVERY - 1);
   localparam logic [PB-1:0] POS_MAX = {1'b0, {(PB - 1){1'b1}}};
   localparam logic [PB-1:0] POS_MIN = {1'b1, {(PB - 1){1'b0}}};

   logic [15:0] base_delay_ff;
   logic [3:0]  speed_gain_ff;
   logic [15:0] jog_timeout_ff;
   logic [15:0] test_period_ff;
   logic        cfg_write;

   logic        in_valid_ff, in_valid_in;
   req_type     req_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        pass_go;
   logic        load_req;

   state_type   state_ff, state_in;
   logic [1:0]  pend_ff, pend_in;
   logic        motor_ff, motor_in;
   logic        relay_ff, relay_in;
   logic        jog_ff, jog_in;
   logic [PB-1:0] pos_ff, pos_in;
   logic [2:0]  res_ff, res_in;
   logic [15:0] delay_ff, delay_in;
   logic [31:0] last_step_ff, last_step_in;
   logic [31:0] prev_step_ff, prev_step_in;
   logic [31:0] last_test_ff, last_test_in;

   logic        p1, p2, p3;
   logic        hit;
   logic [2:0]  mask;
   logic [1:0]  beep;
   logic [3:0]  msg;
   logic        step_right;
   logic [13:0] gain_product;
   logic [16:0] delay_sum;
   logic [15:0] delay_sample;

   function automatic logic [PB-1:0] step_pos(input logic [PB-1:0] pos, input logic right);
      return right ? pos + PB'(1) : pos - PB'(1);
   endfunction

   function automatic logic [2:0] step_res(input logic [PB-1:0] pos, input logic [2:0] res,
                                           input logic right);
      logic [2:0] r;
      if (right) begin
         if (pos == POS_MAX) r = MIN_RES;
         else if (res == RES_LAST) r = 3'd0;
         else r = res + 3'd1;
      end else begin
         if (pos == POS_MIN) r = MAX_RES;
         else if (res == 3'd0) r = RES_LAST;
         else r = res - 3'd1;
      end
      return r;
   endfunction

   function automatic logic [2:0] mode_code(input state_type st);
      logic [2:0] m;
      unique case (st)
         ST_STOP:      m = MODE_STOP;
         ST_POS1:      m = MODE_POS1;
         ST_POS2:      m = MODE_POS2;
         ST_POS3:      m = MODE_POS3;
         ST_CATCH_BOT: m = MODE_CATCH_BOT;
         ST_CATCH_TOP: m = MODE_CATCH_TOP;
         ST_RELEASE:   m = MODE_RELEASE;
         default:      m = MODE_STOP;
      endcase
      return m;
   endfunction

   // Configuration port.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_delay_ff  <= BASE_DELAY_RESET;
         speed_gain_ff  <= SPEED_GAIN_RESET;
         jog_timeout_ff <= JOG_TIMEOUT_RESET;
         test_period_ff <= TEST_PERIOD_RESET;
      end else if (cfg_write) begin
         unique case (paddr[3:2])
            REG_BASE_DELAY:  base_delay_ff  <= pwdata[15:0];
            REG_SPEED_GAIN:  speed_gain_ff  <= pwdata[3:0];
            REG_JOG_TIMEOUT: jog_timeout_ff <= pwdata[15:0];
            REG_TEST_PERIOD: test_period_ff <= pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_BASE_DELAY:  prdata = {16'd0, base_delay_ff};
         REG_SPEED_GAIN:  prdata = {28'd0, speed_gain_ff};
         REG_JOG_TIMEOUT: prdata = {16'd0, jog_timeout_ff};
         REG_TEST_PERIOD: prdata = {16'd0, test_period_ff};
      endcase
   end

   // Beat flow: input register, then response register.
   assign pass_go   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !pass_go;
   assign load_req  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      if (load_req) in_valid_in = 1'b1;
      else if (pass_go) in_valid_in = 1'b0;
      else in_valid_in = in_valid_ff;

      if (pass_go) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   // The resampled delay is the same for every step of a pass.
   assign gain_product = 14'(speed_gain_ff) * 14'(req_ff.speed_sample);
   assign delay_sum    = {1'b0, base_delay_ff} + 17'(gain_product);
   assign delay_sample = delay_sum[16] ? 16'hFFFF : delay_sum[15:0];

   assign p1 = req_ff.position_sensors[0];
   assign p2 = req_ff.position_sensors[1];
   assign p3 = req_ff.position_sensors[2];

   always_comb begin
      state_in     = state_ff;
      pend_in      = (req_ff.host_command != ACT_NONE) ? req_ff.host_command : pend_ff;
      motor_in     = motor_ff;
      relay_in     = relay_ff;
      jog_in       = jog_ff;
      pos_in       = pos_ff;
      res_in       = res_ff;
      last_step_in = last_step_ff;
      prev_step_in = prev_step_ff;
      last_test_in = last_test_ff;
      hit          = 1'b0;
      mask         = 3'd0;
      beep         = BEEP_NONE;
      msg          = MSG_NONE;
      step_right   = 1'b0;

      if (req_ff.goto_buttons[3] || pend_in == ACT_STOP) begin
         pend_in  = ACT_NONE;
         state_in = ST_STOP;
         motor_in = 1'b0;
         msg      = MSG_STOP;
         beep     = BEEP_ATTN;
      end

      if (state_in == ST_STOP) begin
         if (req_ff.goto_buttons[0] || pend_in == ACT_GO_POS1) begin
            pend_in = ACT_NONE;
            if (!p1) begin
               state_in = ST_POS1;
            end else begin
               msg  = MSG_AT_POS1;
               beep = BEEP_ATTN;
            end
         end
         if (req_ff.goto_buttons[1] || pend_in == ACT_GO_POS2) begin
            pend_in = ACT_NONE;
            if (!p2) begin
               if (p1) begin
                  state_in = ST_POS2;
               end else begin
                  msg  = MSG_POS_ERROR;
                  beep = BEEP_ERR;
               end
            end else begin
               msg  = MSG_IN_POS2;
               beep = BEEP_ATTN;
            end
         end
         if (req_ff.goto_buttons[2]) begin
            if (p1) begin
               state_in = ST_POS3;
            end else begin
               msg  = MSG_POS_ERROR;
               beep = BEEP_ERR;
            end
         end
         if (req_ff.sample_buttons[0]) begin
            if (p1) begin
               state_in = ST_CATCH_BOT;
            end else begin
               msg  = MSG_NO_CATCH;
               beep = BEEP_ERR;
            end
         end
         if (req_ff.sample_buttons[1]) begin
            if (p2) begin
               state_in = ST_CATCH_TOP;
            end else begin
               msg  = MSG_NO_CATCH;
               beep = BEEP_ERR;
            end
         end
         if (req_ff.sample_buttons[2]) begin
            if (p2) begin
               state_in = ST_RELEASE;
            end else begin
               msg  = MSG_NO_RELEASE;
               beep = BEEP_ERR;
            end
         end
      end

      unique case (state_in)
         ST_POS1, ST_POS2: begin
            if (!((state_in == ST_POS1) ? p1 : p2)) begin
               last_step_in = req_ff.time_ms;
               step_right   = (state_in == ST_POS2);
               motor_in     = 1'b1;
               res_in       = step_res(pos_in, res_in, step_right);
               pos_in       = step_pos(pos_in, step_right);
               hit          = hit || (res_in == 3'd0);
               mask[0]      = 1'b1;
            end else begin
               msg      = (state_in == ST_POS1) ? MSG_AT_POS1 : MSG_IN_POS2;
               state_in = ST_STOP;
               motor_in = 1'b0;
               beep     = BEEP_ATTN;
            end
         end
         ST_POS3: begin
            if (req_ff.ring_sensors == 3'd0) begin
               step_right = 1'b1;
               motor_in   = 1'b1;
               res_in     = step_res(pos_in, res_in, 1'b1);
               pos_in     = step_pos(pos_in, 1'b1);
               hit        = hit || (res_in == 3'd0);
               mask[0]    = 1'b1;
            end else begin
               state_in = ST_STOP;
               motor_in = 1'b0;
               msg      = MSG_OVER_DETECTOR;
               beep     = BEEP_ATTN;
            end
         end
         ST_CATCH_BOT, ST_CATCH_TOP: begin
            if (req_ff.sample_sensors == 3'b111) begin
               state_in = ST_STOP;
               motor_in = 1'b0;
               relay_in = 1'b1;
               msg      = MSG_CAUGHT;
               beep     = BEEP_ATTN;
            end else begin
               last_step_in = req_ff.time_ms;
               step_right   = 1'b1;
               motor_in     = 1'b1;
               res_in       = step_res(pos_in, res_in, 1'b1);
               pos_in       = step_pos(pos_in, 1'b1);
               hit          = hit || (res_in == 3'd0);
               mask[0]      = 1'b1;
            end
         end
         ST_RELEASE: begin
            relay_in = 1'b0;
            if (req_ff.sample_sensors != 3'd0) begin
               msg  = MSG_FALLING;
               beep = BEEP_ALARM;
            end else begin
               state_in = ST_STOP;
               msg      = MSG_RELEASED;
               beep     = BEEP_ATTN;
            end
         end
         default: begin
         end
      endcase

      if (req_ff.jog_buttons[2]) relay_in = 1'b0;
      if (req_ff.jog_buttons[3]) relay_in = 1'b1;

      if (req_ff.jog_buttons[0]) begin
         jog_in       = 1'b1;
         last_step_in = req_ff.time_ms;
         motor_in     = 1'b1;
         res_in       = step_res(pos_in, res_in, 1'b0);
         pos_in       = step_pos(pos_in, 1'b0);
         hit          = hit || (res_in == 3'd0);
         mask[1]      = 1'b1;
      end
      if (req_ff.jog_buttons[1]) begin
         if (req_ff.ring_sensors != 3'd0) beep = BEEP_ALARM;
         motor_in = 1'b1;
         res_in   = step_res(pos_in, res_in, 1'b1);
         pos_in   = step_pos(pos_in, 1'b1);
         hit      = hit || (res_in == 3'd0);
         mask[2]  = 1'b1;
      end

      if (jog_in) begin
         if ((last_step_in - prev_step_in) < {16'd0, jog_timeout_ff}) begin
            prev_step_in = last_step_in;
         end else begin
            jog_in   = 1'b0;
            motor_in = 1'b0;
         end
      end

      if (req_ff.test_jumper && (req_ff.time_ms - last_test_ff) >= {16'd0, test_period_ff})
      begin
         last_test_in = req_ff.time_ms;
         if (p1) begin
            msg  = MSG_AT_POS1;
            beep = BEEP_ATTN;
         end
         if (p2) begin
            msg  = MSG_TEST_POS2;
            beep = BEEP_ATTN;
         end
         if (p3) begin
            msg  = MSG_TEST_POS3;
            beep = BEEP_ATTN;
         end
      end

      delay_in = hit ? delay_sample : delay_ff;

      rsp_in.mode            = mode_code(state_in);
      rsp_in.motor_enabled   = motor_in;
      rsp_in.step_mask       = mask;
      rsp_in.mode_step_right = step_right;
      rsp_in.relay_on        = relay_in;
      rsp_in.beep_code       = beep;
      rsp_in.message_code    = msg;
      rsp_in.position        = 16'($signed(pos_in));
      rsp_in.step_delay_us   = delay_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ST_STOP;
         pend_ff      <= ACT_NONE;
         motor_ff     <= 1'b0;
         relay_ff     <= 1'b0;
         jog_ff       <= 1'b0;
         pos_ff       <= '0;
         res_ff       <= 3'd0;
         delay_ff     <= BASE_DELAY_RESET;
         last_step_ff <= 32'd0;
         prev_step_ff <= 32'd0;
         last_test_ff <= 32'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pass_go) begin
            state_ff     <= state_in;
            pend_ff      <= pend_in;
            motor_ff     <= motor_in;
            relay_ff     <= relay_in;
            jog_ff       <= jog_in;
            pos_ff       <= pos_in;
            res_ff       <= res_in;
            delay_ff     <= delay_in;
            last_step_ff <= last_step_in;
            prev_step_ff <= prev_step_in;
            last_test_ff <= last_test_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_req) req_ff <= req_data;
      if (pass_go) rsp_ff <= rsp_in;
   end

   // The input register only stalls when the response register is also full.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled while the pipeline has room");

   // A response without a mode step never reports a right mode step.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.step_mask[0]) |-> !rsp_data.mode_step_right)
      else $error("mode step direction set without a mode step");

   // The residue tracker never leaves its range.
   assert property (@(posedge clock) disable iff (reset)
      res_ff <= RES_LAST)
      else $error("position residue out of range");

   // A pass that ends in stop mode never issues a mode step.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.mode == MODE_STOP) |-> !rsp_data.step_mask[0])
      else $error("mode step issued in stop mode");

   // After reset nothing is in flight.
   assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("beat in flight after reset");

endmodule

`default_nettype wire

// ===== tb/spindle_pass_checker.sv =====
`timescale 1ns / 1ps

module spindle_pass_checker
   import sms_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire req_type     req_data,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire rsp_type     rsp_data,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic        pready,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output int               mismatch_count,
   output int               pending_count,
   output int               compared_count
);

   logic [15:0] cfg_base;
   logic [3:0]  cfg_gain;
   logic [15:0] cfg_timeout;
   logic [15:0] cfg_period;

   logic [2:0]  mode_q;
   logic [1:0]  pending_act;
   logic        motor_q;
   logic        relay_q;
   logic        jog_q;
   logic [15:0] pos_q;
   logic [15:0] delay_q;
   logic [31:0] last_step_ms;
   logic [31:0] prev_step_ms;
   logic [31:0] last_test_ms;

   rsp_type expected_passes[$];
   rsp_type predicted;
   rsp_type wanted;

   initial begin
      mismatch_count = 0;
      pending_count = 0;
      compared_count = 0;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("response %0d field %s = %0h, expected %0h",
                                   compared_count, name, got, want));
      end
   endtask

   task automatic take_step(input logic right, input logic [9:0] speed);
      int          signed_pos;
      int unsigned sum;
      pos_q = right ? pos_q + 16'd1 : pos_q - 16'd1;
      signed_pos = $signed(pos_q);
      if (signed_pos % RESAMPLE_EVERY == 0) begin
         sum = 32'(cfg_base) + 32'(cfg_gain) * 32'(speed);
         delay_q = (sum > 32'd65535) ? 16'hFFFF : sum[15:0];
      end
   endtask

   task automatic run_control_pass(input req_type b, output rsp_type r);
      logic       p1;
      logic       p2;
      logic       p3;
      logic [2:0] mask;
      logic [1:0] beep;
      logic [3:0] msg;
      logic       right;
      p1 = b.position_sensors[0];
      p2 = b.position_sensors[1];
      p3 = b.position_sensors[2];
      mask = 3'b000;
      beep = BEEP_NONE;
      msg = MSG_NONE;
      right = 1'b0;

      if (b.host_command != ACT_NONE) pending_act = b.host_command;

      if (b.goto_buttons[3] || pending_act == ACT_STOP) begin
         pending_act = ACT_NONE;
         mode_q = MODE_STOP;
         motor_q = 1'b0;
         msg = MSG_STOP;
         beep = BEEP_ATTN;
      end

      if (mode_q == MODE_STOP) begin
         if (b.goto_buttons[0] || pending_act == ACT_GO_POS1) begin
            pending_act = ACT_NONE;
            if (!p1) mode_q = MODE_POS1;
            else begin
               msg = MSG_AT_POS1;
               beep = BEEP_ATTN;
            end
         end
         if (b.goto_buttons[1] || pending_act == ACT_GO_POS2) begin
            pending_act = ACT_NONE;
            if (!p2) begin
               if (p1) mode_q = MODE_POS2;
               else begin
                  msg = MSG_POS_ERROR;
                  beep = BEEP_ERR;
               end
            end else begin
               msg = MSG_IN_POS2;
               beep = BEEP_ATTN;
            end
         end
         if (b.goto_buttons[2]) begin
            if (p1) mode_q = MODE_POS3;
            else begin
               msg = MSG_POS_ERROR;
               beep = BEEP_ERR;
            end
         end
         if (b.sample_buttons[0]) begin
            if (p1) mode_q = MODE_CATCH_BOT;
            else begin
               msg = MSG_NO_CATCH;
               beep = BEEP_ERR;
            end
         end
         if (b.sample_buttons[1]) begin
            if (p2) mode_q = MODE_CATCH_TOP;
            else begin
               msg = MSG_NO_CATCH;
               beep = BEEP_ERR;
            end
         end
         if (b.sample_buttons[2]) begin
            if (p2) mode_q = MODE_RELEASE;
            else begin
               msg = MSG_NO_RELEASE;
               beep = BEEP_ERR;
            end
         end
      end

      case (mode_q)
         MODE_POS1, MODE_POS2: begin
            if (!((mode_q == MODE_POS1) ? p1 : p2)) begin
               last_step_ms = b.time_ms;
               right = (mode_q == MODE_POS2);
               motor_q = 1'b1;
               take_step(right, b.speed_sample);
               mask[0] = 1'b1;
            end else begin
               msg = (mode_q == MODE_POS1) ? MSG_AT_POS1 : MSG_IN_POS2;
               mode_q = MODE_STOP;
               motor_q = 1'b0;
               beep = BEEP_ATTN;
            end
         end
         MODE_POS3: begin
            if (b.ring_sensors == 3'b000) begin
               right = 1'b1;
               motor_q = 1'b1;
               take_step(1'b1, b.speed_sample);
               mask[0] = 1'b1;
            end else begin
               mode_q = MODE_STOP;
               motor_q = 1'b0;
               msg = MSG_OVER_DETECTOR;
               beep = BEEP_ATTN;
            end
         end
         MODE_CATCH_BOT, MODE_CATCH_TOP: begin
            if (b.sample_sensors == 3'b111) begin
               mode_q = MODE_STOP;
               motor_q = 1'b0;
               relay_q = 1'b1;
               msg = MSG_CAUGHT;
               beep = BEEP_ATTN;
            end else begin
               last_step_ms = b.time_ms;
               right = 1'b1;
               motor_q = 1'b1;
               take_step(1'b1, b.speed_sample);
               mask[0] = 1'b1;
            end
         end
         MODE_RELEASE: begin
            relay_q = 1'b0;
            if (b.sample_sensors != 3'b000) begin
               msg = MSG_FALLING;
               beep = BEEP_ALARM;
            end else begin
               mode_q = MODE_STOP;
               msg = MSG_RELEASED;
               beep = BEEP_ATTN;
            end
         end
         default: ;
      endcase

      if (b.jog_buttons[2]) relay_q = 1'b0;
      if (b.jog_buttons[3]) relay_q = 1'b1;

      if (b.jog_buttons[0]) begin
         jog_q = 1'b1;
         last_step_ms = b.time_ms;
         motor_q = 1'b1;
         take_step(1'b0, b.speed_sample);
         mask[1] = 1'b1;
      end
      if (b.jog_buttons[1]) begin
         if (b.ring_sensors != 3'b000) beep = BEEP_ALARM;
         motor_q = 1'b1;
         take_step(1'b1, b.speed_sample);
         mask[2] = 1'b1;
      end

      if (jog_q) begin
         if (32'(last_step_ms - prev_step_ms) < 32'(cfg_timeout)) begin
            prev_step_ms = last_step_ms;
         end else begin
            jog_q = 1'b0;
            motor_q = 1'b0;
         end
      end

      if (b.test_jumper && 32'(b.time_ms - last_test_ms) >= 32'(cfg_period)) begin
         last_test_ms = b.time_ms;
         if (p1) begin
            msg = MSG_AT_POS1;
            beep = BEEP_ATTN;
         end
         if (p2) begin
            msg = MSG_TEST_POS2;
            beep = BEEP_ATTN;
         end
         if (p3) begin
            msg = MSG_TEST_POS3;
            beep = BEEP_ATTN;
         end
      end

      r.mode = mode_q;
      r.motor_enabled = motor_q;
      r.step_mask = mask;
      r.mode_step_right = right;
      r.relay_on = relay_q;
      r.beep_code = beep;
      r.message_code = msg;
      r.position = pos_q;
      r.step_delay_us = delay_q;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_base = BASE_DELAY_RESET;
         cfg_gain = SPEED_GAIN_RESET;
         cfg_timeout = JOG_TIMEOUT_RESET;
         cfg_period = TEST_PERIOD_RESET;
         mode_q = MODE_STOP;
         pending_act = ACT_NONE;
         motor_q = 1'b0;
         relay_q = 1'b0;
         jog_q = 1'b0;
         pos_q = 16'd0;
         delay_q = BASE_DELAY_RESET;
         last_step_ms = 32'd0;
         prev_step_ms = 32'd0;
         last_test_ms = 32'd0;
         expected_passes.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_BASE_DELAY:  cfg_base = pwdata[15:0];
               REG_SPEED_GAIN:  cfg_gain = pwdata[3:0];
               REG_JOG_TIMEOUT: cfg_timeout = pwdata[15:0];
               REG_TEST_PERIOD: cfg_period = pwdata[15:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_passes.size() == 0) begin
               report_mismatch("response beat with no request outstanding");
            end else begin
               wanted = expected_passes.pop_front();
               check_field("mode", 32'(rsp_data.mode), 32'(wanted.mode));
               check_field("motor_enabled", 32'(rsp_data.motor_enabled),
                           32'(wanted.motor_enabled));
               check_field("step_mask", 32'(rsp_data.step_mask), 32'(wanted.step_mask));
               check_field("mode_step_right", 32'(rsp_data.mode_step_right),
                           32'(wanted.mode_step_right));
               check_field("relay_on", 32'(rsp_data.relay_on), 32'(wanted.relay_on));
               check_field("beep_code", 32'(rsp_data.beep_code), 32'(wanted.beep_code));
               check_field("message_code", 32'(rsp_data.message_code),
                           32'(wanted.message_code));
               check_field("position", 32'(rsp_data.position), 32'(wanted.position));
               check_field("step_delay_us", 32'(rsp_data.step_delay_us),
                           32'(wanted.step_delay_us));
               compared_count++;
            end
         end
         if (req_valid && !req_stall) begin
            run_control_pass(req_data, predicted);
            expected_passes.push_back(predicted);
         end
      end
      pending_count = expected_passes.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import sms_pkg::*;

   localparam int LONG_HOLD = 300;
   localparam int PHASE_BEATS = 180;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   req_type     req_data = '0;
   logic        rsp_stall = 1'b0;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = 4'd0;
   logic [31:0] pwdata = 32'd0;

   logic        req_stall;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic [31:0] prdata;
   logic        pready;

   int mismatch_count;
   int pending_count;
   int compared_count;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_seq = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int beats_sent = 0;

   logic [2:0]  pos_lvl = 3'b000;
   logic [2:0]  ring_lvl = 3'b000;
   logic [2:0]  samp_lvl = 3'b000;
   logic        jumper_lvl = 1'b0;
   logic [31:0] now_ms = 32'd0;
   int unsigned max_gap = 150;

   spindle_motion_sequencer_top DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   spindle_pass_checker pass_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .pready(pready),
      .paddr(paddr),
      .pwdata(pwdata),
      .mismatch_count(mismatch_count),
      .pending_count(pending_count),
      .compared_count(compared_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // A long hold-off is requested by bumping hold_seq and counted down here.
   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen = hold_seq;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic send_beat(input req_type b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data <= b;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= {16'($urandom_range(0, 65535)), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic set_config(input logic [15:0] base, input logic [3:0] gain,
                             input logic [15:0] timeout, input logic [15:0] period);
      drain();
      write_reg(REG_BASE_DELAY, base);
      write_reg(REG_SPEED_GAIN, {12'($urandom_range(0, 4095)), gain});
      write_reg(REG_JOG_TIMEOUT, timeout);
      write_reg(REG_TEST_PERIOD, period);
      repeat (2) @(posedge clock);
   endtask

   function automatic req_type mk(input logic [1:0] act, input logic [3:0] gb,
                                  input logic [2:0] sb, input logic [3:0] jb,
                                  input logic [2:0] ps, input logic [2:0] rs,
                                  input logic [2:0] ss, input logic jmp,
                                  input logic [31:0] t, input logic [9:0] spd);
      req_type b;
      b.host_command = act;
      b.goto_buttons = gb;
      b.sample_buttons = sb;
      b.jog_buttons = jb;
      b.position_sensors = ps;
      b.ring_sensors = rs;
      b.sample_sensors = ss;
      b.test_jumper = jmp;
      b.time_ms = t;
      b.speed_sample = spd;
      return b;
   endfunction

   function automatic req_type quiet_beat();
      req_type b;
      if ($urandom_range(0, 15) == 0) now_ms = now_ms + $urandom;
      else now_ms = now_ms + $urandom_range(0, max_gap);
      b = mk(ACT_NONE, 4'b0000, 3'b000, 4'b0000, pos_lvl, ring_lvl, samp_lvl,
             jumper_lvl, now_ms, 10'($urandom_range(0, 1023)));
      return b;
   endfunction

   function automatic req_type stir(input req_type b);
      req_type s;
      s = b;
      if ($urandom_range(0, 9) == 0) s.jog_buttons = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 9) == 0) s.host_command = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 24) == 0) s.goto_buttons[3] = 1'b1;
      if ($urandom_range(0, 24) == 0) s.sample_buttons = 3'($urandom_range(0, 7));
      return s;
   endfunction

   task automatic run_sequence();
      req_type     b;
      logic [64:0] raw;
      int          kind;
      int          target;
      int          n;
      kind = $urandom_range(0, 9);
      n = $urandom_range(1, 12);
      case (kind)
         0, 1, 2: begin
            target = $urandom_range(1, 3);
            if (target == 1) begin
               pos_lvl[0] = ($urandom_range(0, 7) == 0);
            end else begin
               pos_lvl[0] = ($urandom_range(0, 7) != 0);
               pos_lvl[1] = ($urandom_range(0, 7) == 0);
               if (target == 3) ring_lvl = 3'b000;
            end
            b = quiet_beat();
            if (target == 3) b.goto_buttons[2] = 1'b1;
            else if ($urandom_range(0, 1) == 1) b.goto_buttons[target - 1] = 1'b1;
            else b.host_command = (target == 1) ? ACT_GO_POS1 : ACT_GO_POS2;
            send_beat(b);
            repeat (n) send_beat(stir(quiet_beat()));
            if (target == 3) ring_lvl = 3'($urandom_range(1, 7));
            else pos_lvl[target - 1] = 1'b1;
            send_beat(quiet_beat());
            send_beat(quiet_beat());
         end
         3, 4: begin
            target = $urandom_range(0, 2);
            pos_lvl = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 9) != 0) pos_lvl[(target == 0) ? 0 : 1] = 1'b1;
            samp_lvl = (target == 2) ? 3'($urandom_range(1, 7)) : 3'($urandom_range(0, 6));
            b = quiet_beat();
            b.sample_buttons[target] = 1'b1;
            send_beat(b);
            repeat (n) begin
               samp_lvl = (target == 2) ? 3'($urandom_range(1, 7))
                                        : 3'($urandom_range(0, 6));
               send_beat(stir(quiet_beat()));
            end
            samp_lvl = (target == 2) ? 3'b000 : 3'b111;
            send_beat(quiet_beat());
            send_beat(quiet_beat());
         end
         5, 6: begin
            repeat (n + 3) begin
               ring_lvl = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'b000;
               b = quiet_beat();
               b.jog_buttons = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                          : 4'b0001;
               send_beat(b);
            end
         end
         7: begin
            jumper_lvl = 1'b1;
            repeat (n) begin
               pos_lvl = 3'($urandom_range(0, 7));
               send_beat(stir(quiet_beat()));
            end
            jumper_lvl = 1'($urandom_range(0, 1));
         end
         default: begin
            repeat ((n + 1) / 2) begin
               raw = {1'($urandom), $urandom, $urandom};
               b = raw;
               if ($urandom_range(0, 1) == 1) begin
                  now_ms = now_ms + $urandom_range(0, max_gap);
                  b.time_ms = now_ms;
               end
               send_beat(b);
            end
         end
      endcase
   endtask

   task automatic directed_beats();
      send_beat(mk(ACT_NONE, 4'b0000, 3'b000, 4'b0000, 3'b000, 3'b000, 3'b000, 1'b0,
                   32'd0, 10'd0));
      send_beat(mk(ACT_STOP, 4'b1000, 3'b000, 4'b0000, 3'b111, 3'b111, 3'b111, 1'b0,
                   32'd10, 10'd1023));
      send_beat(mk(ACT_GO_POS1, 4'b0000, 3'b000, 4'b0000, 3'b001, 3'b000, 3'b000, 1'b0,
                   32'd20, 10'd5));
      send_beat(mk(ACT_NONE, 4'b0010, 3'b000, 4'b0000, 3'b010, 3'b000, 3'b000, 1'b0,
                   32'd30, 10'd5));
      send_beat(mk(ACT_GO_POS2, 4'b0000, 3'b000, 4'b0000, 3'b000, 3'b000, 3'b000, 1'b0,
                   32'd40, 10'd5));
      send_beat(mk(ACT_NONE, 4'b0100, 3'b111, 4'b0000, 3'b000, 3'b000, 3'b000, 1'b0,
                   32'd50, 10'd5));
      // Every start request at once: the release of the top claw wins.
      send_beat(mk(ACT_NONE, 4'b0111, 3'b111, 4'b0000, 3'b011, 3'b000, 3'b111, 1'b0,
                   32'd60, 10'd1023));
      send_beat(mk(ACT_NONE, 4'b0000, 3'b000, 4'b0000, 3'b011, 3'b000, 3'b000, 1'b0,
                   32'd70, 10'd0));
      send_beat(mk(ACT_NONE, 4'b0001, 3'b000, 4'b0000, 3'b000, 3'b000, 3'b000, 1'b0,
                   32'd80, 10'd1023));
      for (int i = 1; i <= 4; i++) begin
         send_beat(mk(ACT_NONE, 4'b0000, 3'b000, 4'b0000, 3'b000, 3'b000, 3'b000, 1'b0,
                      32'd80 + 32'(i), 10'd1023));
      end
      // A serial request while moving stays pending until stop mode.
      send_beat(mk(ACT_GO_POS2, 4'b0000, 3'b000, 4'b0000, 3'b000, 3'b000, 3'b000, 1'b0,
                   32'd85, 10'd7));
      send_beat(mk(ACT_NONE, 4'b0000, 3'b000, 4'b0000, 3'b001, 3'b000, 3'b000, 1'b0,
                   32'd90, 10'd0));
      send_beat(mk(ACT_NONE, 4'b0000, 3'b000, 4'b0000, 3'b001, 3'b000, 3'b000, 1'b0,
                   32'd95, 10'd0));
      send_beat(mk(ACT_NONE, 4'b0000, 3'b000, 4'b1111, 3'b010, 3'b101, 3'b000, 1'b0,
                   32'd100, 10'd1023));
      send_beat(mk(ACT_NONE, 4'b0000, 3'b001, 4'b0000, 3'b001, 3'b000, 3'b111, 1'b0,
                   32'd110, 10'd0));
      send_beat(mk(ACT_NONE, 4'b0000, 3'b010, 4'b0000, 3'b010, 3'b000, 3'b011, 1'b0,
                   32'd120, 10'd0));
      send_beat(mk(ACT_NONE, 4'b0000, 3'b000, 4'b0000, 3'b010, 3'b000, 3'b111, 1'b0,
                   32'd130, 10'd0));
      send_beat(mk(ACT_NONE, 4'b0100, 3'b000, 4'b0000, 3'b001, 3'b000, 3'b000, 1'b0,
                   32'd140, 10'd0));
      send_beat(mk(ACT_NONE, 4'b0000, 3'b000, 4'b0000, 3'b001, 3'b010, 3'b000, 1'b0,
                   32'd150, 10'd0));
      send_beat(mk(ACT_NONE, 4'b0000, 3'b000, 4'b0001, 3'b000, 3'b000, 3'b000, 1'b1,
                   32'd300, 10'd9));
      send_beat(mk(ACT_NONE, 4'b0000, 3'b000, 4'b0001, 3'b111, 3'b000, 3'b000, 1'b1,
                   32'd500, 10'd9));
      send_beat(mk(ACT_GO_POS2, 4'b1111, 3'b111, 4'b1111, 3'b111, 3'b111, 3'b111, 1'b1,
                   32'hFFFF_FFFF, 10'h3FF));
   endtask

   initial begin
      int phase_start;
      bit paused;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_beats();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            1: begin
               set_config(16'd0, 4'd0, 16'd1, 16'd1);
               max_gap = 3;
            end
            2: begin
               set_config(16'hFFFF, 4'hF, 16'hFFFF, 16'hFFFF);
               max_gap = 200;
            end
            3: begin
               set_config(16'd60000, 4'hF, 16'd0, 16'd0);
               max_gap = 40;
            end
            4: begin
               set_config(16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)),
                          16'($urandom_range(1, 300)), 16'($urandom_range(1, 600)));
               max_gap = 150;
               now_ms = 32'hFFFF_F000;
            end
            5: begin
               set_config(16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)),
                          16'd20, 16'd50);
               max_gap = 40;
            end
            default: ;
         endcase
         phase_start = beats_sent;
         paused = 1'b0;
         if (phase == 1 || phase == 4) begin
            send_idle_pct = 0;
            stall_pct = 0;
            hold_seq++;
            while (beats_sent - phase_start < 30) run_sequence();
         end
         while (beats_sent - phase_start < PHASE_BEATS) begin
            case ((beats_sent / 45) % 4)
               0: begin
                  send_idle_pct = 0;
                  stall_pct = 0;
               end
               1: begin
                  send_idle_pct = 49;
                  stall_pct = 0;
               end
               2: begin
                  send_idle_pct = 0;
                  stall_pct = 49;
               end
               default: begin
                  send_idle_pct = 9;
                  stall_pct = 9;
               end
            endcase
            run_sequence();
            if (!paused && beats_sent - phase_start >= PHASE_BEATS / 2) begin
               paused = 1'b1;
               drain();
            end
         end
      end
      drain();
      $display("Sent %0d request beats over six register settings and four idle patterns.",
               beats_sent);
      $display("Compared %0d response beats and found %0d mismatches.",
               compared_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/sms_pkg.sv
design/spindle_motion_sequencer_top.sv
tb/spindle_pass_checker.sv
tb/tb.sv
